@@ rtl/bspa_pkg.sv @@
`default_nettype none

package bspa_pkg;

  // Field widths of the ports.
  localparam int FUNC_W     = 2;
  localparam int BLK_W      = 4;
  localparam int SLOT_W     = 6;
  localparam int STATUS_W   = 2;
  localparam int IN_USE_W   = 11;
  localparam int EPB_W      = 7;
  localparam int NBLK_W     = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  // Operation codes.
  localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_FREE = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_EPB  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NBLK = 1'b1;

  // Configuration reset values.
  localparam logic [EPB_W-1:0]  EPB_RST  = 7'd64;
  localparam logic [NBLK_W-1:0] NBLK_RST = 5'd16;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic exec;      // execute the item on the input ports
    logic walk;      // write one identity entry of the clearing pass
    logic load_out;  // move the pending result into the output register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_op;   // item on the input ports is a clear
    logic walk_last;  // clearing pass is at its last entry
  } dp_stat_t;

endpackage

`default_nettype wire

@@ rtl/bspa_ram.sv @@
`default_nettype none

module bspa_ram #(
  parameter int WIDTH  = 6,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/bspa_ctrl.sv @@
`default_nettype none

module bspa_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output bspa_pkg::dp_cmd_t  cmd,
  input  bspa_pkg::dp_stat_t stat
);

  import bspa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_CLEAR = 3'b010,
    S_DONE  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;
  logic   emit;
  logic   emit_next;
  logic   out_valid_next;
  logic   accept;
  logic   can_load;

  assign accept   = (state == S_IDLE) && in_valid;
  assign can_load = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  // Sequencing of one item and of the clearing pass.
  always_comb begin
    state_next = state;
    emit_next  = emit;
    cmd        = '0;
    cmd.exec   = accept;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (stat.clear_op) begin
            state_next = S_CLEAR;
            emit_next  = 1'b1;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_CLEAR: begin
        cmd.walk = 1'b1;
        if (stat.walk_last) begin
          state_next = emit ? S_DONE : S_IDLE;
        end
      end
      S_DONE: begin
        if (can_load) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Output register occupancy.
  always_comb begin
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  // The clearing pass after reset produces no result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      emit      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      emit      <= emit_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/bspa_dp.sv @@
`default_nettype none

module bspa_dp #(
  parameter int MAX_SLOTS_PER_BLOCK = 64,
  parameter int MAX_BLOCKS          = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [bspa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bspa_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [bspa_pkg::FUNC_W-1:0]         func,
  input  logic [bspa_pkg::BLK_W-1:0]          free_block,
  input  logic [bspa_pkg::SLOT_W-1:0]         free_slot,
  input  bspa_pkg::dp_cmd_t                   cmd,
  output bspa_pkg::dp_stat_t                  stat,
  output logic [bspa_pkg::BLK_W-1:0]          alloc_block,
  output logic [bspa_pkg::SLOT_W-1:0]         alloc_slot,
  output logic [bspa_pkg::STATUS_W-1:0]       status,
  output logic [bspa_pkg::IN_USE_W-1:0]       in_use
);

  import bspa_pkg::*;

  localparam int DEPTH = MAX_BLOCKS * MAX_SLOTS_PER_BLOCK;
  localparam int CW    = $clog2(MAX_SLOTS_PER_BLOCK + 1);
  localparam int NBW   = $clog2(MAX_BLOCKS + 1);
  localparam int BW    = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int IW    = (MAX_SLOTS_PER_BLOCK > 1) ? $clog2(MAX_SLOTS_PER_BLOCK) : 1;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int TW    = $clog2(DEPTH + 1);

  logic [EPB_W-1:0]    epb_reg;
  logic [NBLK_W-1:0]   nblk_reg;
  logic [CW-1:0]       used [MAX_BLOCKS];
  logic [TW-1:0]       total;
  logic [BW-1:0]       walk_blk;
  logic [IW-1:0]       walk_idx;
  logic                res_alloc;
  logic [BLK_W-1:0]    res_block;
  logic [STATUS_W-1:0] res_status;

  logic [CW-1:0]       epb_eff;
  logic [NBW-1:0]      nb_eff;
  logic [TW-1:0]       limit;
  logic                found;
  logic [BW-1:0]       pick;
  logic [BW-1:0]       sel_blk;
  logic [CW-1:0]       sel_used;
  logic                alloc_ok;
  logic                free_ok;
  logic                free_in_range;
  logic                is_alloc;
  logic                do_pop;
  logic                do_push;
  logic [IW-1:0]       op_idx;
  logic [AW-1:0]       op_addr;
  logic [AW-1:0]       walk_addr;
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [SLOT_W-1:0]   ram_wdata;
  logic [SLOT_W-1:0]   ram_rdata;
  logic [STATUS_W-1:0] op_status;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      epb_reg  <= EPB_RST;
      nblk_reg <= NBLK_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_EPB:  epb_reg  <= cfg_data;
        CFG_NBLK: nblk_reg <= NBLK_W'(cfg_data);
        default: ;
      endcase
    end
  end

  // Effective settings: zero counts as one, large values saturate.
  always_comb begin
    if (epb_reg == '0) begin
      epb_eff = CW'(1);
    end else if (32'(epb_reg) > 32'(MAX_SLOTS_PER_BLOCK)) begin
      epb_eff = CW'(MAX_SLOTS_PER_BLOCK);
    end else begin
      epb_eff = CW'(epb_reg);
    end
    if (nblk_reg == '0) begin
      nb_eff = NBW'(1);
    end else if (32'(nblk_reg) > 32'(MAX_BLOCKS)) begin
      nb_eff = NBW'(MAX_BLOCKS);
    end else begin
      nb_eff = NBW'(nblk_reg);
    end
  end

  assign limit = TW'(TW'(epb_eff) * TW'(nb_eff));

  // Priority pick of the lowest enabled block that has a free slot.
  always_comb begin
    found = 1'b0;
    pick  = '0;
    for (int b = MAX_BLOCKS - 1; b >= 0; b--) begin
      if (32'(b) < 32'(nb_eff) && used[b] < epb_eff) begin
        found = 1'b1;
        pick  = BW'(b);
      end
    end
  end

  // Decode of the item on the input ports.
  assign is_alloc      = (func == FUNC_ALLOC);
  assign free_in_range = 32'(free_block) < 32'(nb_eff);
  assign sel_blk       = is_alloc ? pick : BW'(free_block);
  assign sel_used      = used[sel_blk];
  assign alloc_ok      = found && (total < limit);
  assign free_ok       = free_in_range && (sel_used != '0);
  assign do_pop        = cmd.exec && is_alloc && alloc_ok;
  assign do_push       = cmd.exec && (func == FUNC_FREE) && free_ok;

  // Pop reads at the count, push writes one below it.
  assign op_idx    = is_alloc ? IW'(sel_used) : IW'(sel_used - CW'(1));
  assign op_addr   = AW'(32'(sel_blk) * MAX_SLOTS_PER_BLOCK) + AW'(op_idx);
  assign walk_addr = AW'(32'(walk_blk) * MAX_SLOTS_PER_BLOCK) + AW'(walk_idx);

  assign ram_we    = do_push || cmd.walk;
  assign ram_waddr = cmd.walk ? walk_addr : op_addr;
  assign ram_wdata = cmd.walk ? SLOT_W'(walk_idx) : free_slot;

  assign stat.clear_op  = (func == FUNC_CLEAR);
  assign stat.walk_last = (walk_blk == BW'(MAX_BLOCKS - 1)) &&
                          (walk_idx == IW'(MAX_SLOTS_PER_BLOCK - 1));

  bspa_ram #(
    .WIDTH  (SLOT_W),
    .DEPTH  (DEPTH),
    .ADDR_W (AW)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (do_pop),
    .raddr (op_addr),
    .rdata (ram_rdata)
  );

  // Block counts, total count and the clearing pass pointer.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int b = 0; b < MAX_BLOCKS; b++) begin
        used[b] <= '0;
      end
      total    <= '0;
      walk_blk <= '0;
      walk_idx <= '0;
    end else begin
      if (cmd.exec && stat.clear_op) begin
        for (int b = 0; b < MAX_BLOCKS; b++) begin
          used[b] <= '0;
        end
        total <= '0;
      end else if (do_pop) begin
        used[sel_blk] <= sel_used + CW'(1);
        total         <= total + TW'(1);
      end else if (do_push) begin
        used[sel_blk] <= sel_used - CW'(1);
        if (total != '0) begin
          total <= total - TW'(1);
        end
      end
      if (cmd.walk) begin
        if (walk_idx == IW'(MAX_SLOTS_PER_BLOCK - 1)) begin
          walk_idx <= '0;
          if (walk_blk == BW'(MAX_BLOCKS - 1)) begin
            walk_blk <= '0;
          end else begin
            walk_blk <= walk_blk + BW'(1);
          end
        end else begin
          walk_idx <= walk_idx + IW'(1);
        end
      end
    end
  end

  // Status of the item being executed.
  always_comb begin
    priority if (func == FUNC_ALLOC) begin
      op_status = alloc_ok ? ST_OK : ST_FULL;
    end else if (func == FUNC_FREE) begin
      op_status = free_ok ? ST_OK : ST_BAD_FREE;
    end else begin
      op_status = ST_OK;
    end
  end

  // Pending result, completed by the stack read data.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_alloc  <= do_pop;
      res_block  <= BLK_W'(pick);
      res_status <= op_status;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      alloc_block <= res_alloc ? res_block : '0;
      alloc_slot  <= res_alloc ? ram_rdata : '0;
      status      <= res_status;
      in_use      <= IN_USE_W'(total);
    end
  end

endmodule

`default_nettype wire

@@ rtl/blocked_slot_pool_allocator_top.sv @@
`default_nettype none

// Slot pool allocator over MAX_BLOCKS blocks of MAX_SLOTS_PER_BLOCK slots, each
// block keeping a stack of free slot numbers in one shared single-port-write RAM.
// For allocate, free and any unused operation, the block pick, the count update
// and the stack RAM access happen at the accepting edge. From S_DONE the result
// is loaded into the output register once that register is free or being taken.
// The next item is accepted once that result is in the output register, so the
// block takes no new item while one is in progress. A clear, and the clearing
// pass that runs right after reset, write the identity order back into every
// stack entry one per cycle, MAX_BLOCKS * MAX_SLOTS_PER_BLOCK entries (1024 by
// default), while in_stall stays high; a clear item gives its result after the pass.
// Configuration writes are taken at any time but are meant for an idle block.

module blocked_slot_pool_allocator_top #(
  parameter int MAX_SLOTS_PER_BLOCK = 64,
  parameter int MAX_BLOCKS          = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [bspa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bspa_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [bspa_pkg::FUNC_W-1:0]     func,
  input  logic [bspa_pkg::BLK_W-1:0]      free_block,
  input  logic [bspa_pkg::SLOT_W-1:0]     free_slot,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [bspa_pkg::BLK_W-1:0]      alloc_block,
  output logic [bspa_pkg::SLOT_W-1:0]     alloc_slot,
  output logic [bspa_pkg::STATUS_W-1:0]   status,
  output logic [bspa_pkg::IN_USE_W-1:0]   in_use
);

  import bspa_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  bspa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  bspa_dp #(
    .MAX_SLOTS_PER_BLOCK (MAX_SLOTS_PER_BLOCK),
    .MAX_BLOCKS          (MAX_BLOCKS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .func        (func),
    .free_block  (free_block),
    .free_slot   (free_slot),
    .cmd         (cmd),
    .stat        (stat),
    .alloc_block (alloc_block),
    .alloc_slot  (alloc_slot),
    .status      (status),
    .in_use      (in_use)
  );

  // An accepted item holds off the next one.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("item accepted while the previous one was still in progress");

  // A result with a failure status carries no slot.
  a_fail_no_slot: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> (alloc_block == '0 && alloc_slot == '0))
    else $error("failed operation reported a slot");

  // The total count never exceeds the pool size.
  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (32'(in_use) <= 32'(MAX_BLOCKS * MAX_SLOTS_PER_BLOCK)))
    else $error("in_use above pool size");

  // A fresh result only appears after an item has been accepted.
  a_result_has_item: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without an item in progress");

endmodule

`default_nettype wire

@@ tb/tb_blocked_slot_pool_allocator_top.sv @@
`timescale 1ns / 1ps

module tb_blocked_slot_pool_allocator_top;
  import bspa_pkg::*;

  localparam int SLOTS_PER_BLOCK = 64;
  localparam int NUM_BLOCKS      = 16;
  localparam int IDLE_LIMIT      = 5000;
  localparam int PHASE_ITEMS     = 66;
  localparam int NUM_PHASES      = 6;

  // Operation code that leaves the pool alone.
  localparam logic [FUNC_W-1:0] FUNC_NOP = 2'd3;

  typedef struct packed {
    logic [BLK_W-1:0]    blk;
    logic [SLOT_W-1:0]   slot;
    logic [STATUS_W-1:0] code;
    logic [IN_USE_W-1:0] used;
  } pool_result_t;

  // Tracks the free stacks and counts of the pool and holds the results that
  // the accepted items should produce, oldest first.
  class slot_pool_tracker;
    logic [SLOT_W-1:0] stack_mem [NUM_BLOCKS*SLOTS_PER_BLOCK];
    int unsigned       blk_used [NUM_BLOCKS];
    int unsigned       total_used;
    int unsigned       epb_reg;
    int unsigned       nblk_reg;
    pool_result_t      expected_results [$];
    int unsigned       errors;

    function new();
      epb_reg  = EPB_RST;
      nblk_reg = NBLK_RST;
      errors   = 0;
      wipe();
    endfunction

    // Identity order in every stack, nothing in use.
    function void wipe();
      for (int b = 0; b < NUM_BLOCKS; b++) begin
        for (int i = 0; i < SLOTS_PER_BLOCK; i++)
          stack_mem[b*SLOTS_PER_BLOCK + i] = SLOT_W'(i);
        blk_used[b] = 0;
      end
      total_used = 0;
    endfunction

    // Register values as the block uses them: zero counts as one, large
    // values saturate.
    function int unsigned eff_epb();
      if (epb_reg == 0) return 1;
      if (epb_reg > SLOTS_PER_BLOCK) return SLOTS_PER_BLOCK;
      return epb_reg;
    endfunction

    function int unsigned eff_nblk();
      if (nblk_reg == 0) return 1;
      if (nblk_reg > NUM_BLOCKS) return NUM_BLOCKS;
      return nblk_reg;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_EPB)
        epb_reg = data[EPB_W-1:0];
      else
        nblk_reg = data[NBLK_W-1:0];
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction

    // A random block in range that holds at least one slot, for well-formed frees.
    function logic [BLK_W-1:0] pick_busy_block(logic [BLK_W-1:0] fallback);
      int unsigned nb;
      int unsigned start;
      nb    = eff_nblk();
      start = $urandom_range(0, nb - 1);
      for (int k = 0; k < nb; k++)
        if (blk_used[(start + k) % nb] != 0) return BLK_W'((start + k) % nb);
      return fallback;
    endfunction

    // Apply one accepted item and queue the result it should give.
    function void note_op(logic [FUNC_W-1:0] f, logic [BLK_W-1:0] b,
                          logic [SLOT_W-1:0] s);
      pool_result_t r;
      int unsigned  epb;
      int unsigned  nb;
      int unsigned  pick;
      epb  = eff_epb();
      nb   = eff_nblk();
      r    = '0;
      pick = nb;
      if (f == FUNC_ALLOC) begin
        if (total_used < epb * nb) begin
          for (int i = 0; i < nb; i++) begin
            if (blk_used[i] < epb) begin
              pick = i;
              break;
            end
          end
        end
        if (pick >= nb) begin
          r.code = ST_FULL;
        end else begin
          r.blk  = BLK_W'(pick);
          r.slot = stack_mem[pick*SLOTS_PER_BLOCK + blk_used[pick]];
          blk_used[pick]++;
          total_used++;
        end
      end else if (f == FUNC_FREE) begin
        if (b >= nb || blk_used[b] == 0) begin
          r.code = ST_BAD_FREE;
        end else begin
          // The slot number goes back as given, without any check.
          blk_used[b]--;
          stack_mem[b*SLOTS_PER_BLOCK + blk_used[b]] = s;
          if (total_used > 0) total_used--;
        end
      end else if (f == FUNC_CLEAR) begin
        wipe();
      end
      r.used = IN_USE_W'(total_used);
      expected_results.push_back(r);
    endfunction

    // Compare one accepted result with the oldest expectation.
    function void check_result(logic [BLK_W-1:0] blk, logic [SLOT_W-1:0] slot,
                               logic [STATUS_W-1:0] code, logic [IN_USE_W-1:0] used);
      pool_result_t want;
      if (expected_results.size() == 0) begin
        $error("result with no item pending: alloc_block %0d alloc_slot %0d status %0d in_use %0d",
               blk, slot, code, used);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      if (blk !== want.blk) begin
        $error("alloc_block: expected %0d, actual %0d", want.blk, blk);
        errors++;
      end
      if (slot !== want.slot) begin
        $error("alloc_slot: expected %0d, actual %0d", want.slot, slot);
        errors++;
      end
      if (code !== want.code) begin
        $error("status: expected %0d, actual %0d", want.code, code);
        errors++;
      end
      if (used !== want.used) begin
        $error("in_use: expected %0d, actual %0d", want.used, used);
        errors++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [FUNC_W-1:0]     func = '0;
  logic [BLK_W-1:0]      free_block = '0;
  logic [SLOT_W-1:0]     free_slot = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b1;
  logic [BLK_W-1:0]      alloc_block;
  logic [SLOT_W-1:0]     alloc_slot;
  logic [STATUS_W-1:0]   status;
  logic [IN_USE_W-1:0]   in_use;

  slot_pool_tracker tracker;
  int               in_burst = 0;
  int               out_burst = 0;
  int               out_hold = 0;
  logic             out_taken = 1'b0;
  int               idle_cycles = 0;

  blocked_slot_pool_allocator_top #(
    .MAX_SLOTS_PER_BLOCK(SLOTS_PER_BLOCK),
    .MAX_BLOCKS(NUM_BLOCKS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .func(func),
    .free_block(free_block),
    .free_slot(free_slot),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .alloc_block(alloc_block),
    .alloc_slot(alloc_slot),
    .status(status),
    .in_use(in_use)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Idle cycles before the next item: mostly random, with runs of no idling.
  function automatic int draw_idle(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      burst = $urandom_range(8, 30);
      return 0;
    end
    return $urandom_range(0, 13);
  endfunction

  // Result side: after each accepted result, stall for a drawn number of cycles.
  always @(negedge clk) begin
    if (out_taken) out_hold = draw_idle(out_burst);
    if (out_hold > 0) begin
      out_stall <= 1'b1;
      out_hold = out_hold - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Result checking and the watchdog on cycles with no handshake.
  always @(posedge clk) begin
    if (rst) begin
      out_taken   <= 1'b0;
      idle_cycles <= 0;
    end else begin
      out_taken <= out_valid && !out_stall;
      if (out_valid && !out_stall)
        tracker.check_result(alloc_block, alloc_slot, status, in_use);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_blocked_slot_pool_allocator_top: errors");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Present one item after a drawn gap and hold it until it is accepted.
  task automatic send_item(logic [FUNC_W-1:0] f, logic [BLK_W-1:0] b,
                           logic [SLOT_W-1:0] s);
    int gap;
    gap = draw_idle(in_burst);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    func       <= f;
    free_block <= b;
    free_slot  <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_op(f, b, s);
  endtask

  // Random item: mostly allocations and frees of blocks that hold slots.
  task automatic send_random_item(int unsigned alloc_pct);
    int unsigned       roll;
    logic [FUNC_W-1:0] f;
    logic [BLK_W-1:0]  b;
    logic [SLOT_W-1:0] s;
    roll = $urandom_range(0, 99);
    b    = BLK_W'($urandom_range(0, NUM_BLOCKS - 1));
    s    = SLOT_W'($urandom_range(0, SLOTS_PER_BLOCK - 1));
    if (roll < alloc_pct) begin
      f = FUNC_ALLOC;
    end else if (roll < 93) begin
      f = FUNC_FREE;
      if (roll < 85) b = tracker.pick_busy_block(b);
    end else if (roll < 97) begin
      f = FUNC_NOP;
    end else begin
      f = FUNC_CLEAR;
    end
    send_item(f, b, s);
  endtask

  // Drop valid and wait until every expected result has come back.
  task automatic wait_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    tracker.set_reg(idx, data);
  endtask

  initial begin
    tracker = new();
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // Reset settings: pops, a push of a given slot, a free of an empty block,
    // the unused code and a clear.
    send_item(FUNC_ALLOC, 4'd0, 6'd0);
    send_item(FUNC_ALLOC, 4'd15, 6'd63);
    send_item(FUNC_FREE, 4'd15, 6'd63);
    send_item(FUNC_FREE, 4'd0, 6'd63);
    send_item(FUNC_ALLOC, 4'd0, 6'd0);
    send_item(FUNC_NOP, 4'd15, 6'd63);
    send_item(FUNC_CLEAR, 4'd0, 6'd0);
    send_item(FUNC_ALLOC, 4'd0, 6'd0);

    // Zero in both registers means one slot in one block; the slot already in
    // use makes the pool full at once.
    wait_drain();
    write_reg(CFG_EPB, 7'd0);
    write_reg(CFG_NBLK, 7'd0);
    send_item(FUNC_ALLOC, 4'd0, 6'd0);
    send_item(FUNC_FREE, 4'd1, 6'd5);
    send_item(FUNC_FREE, 4'd0, 6'd42);
    send_item(FUNC_ALLOC, 4'd0, 6'd0);
    send_item(FUNC_ALLOC, 4'd0, 6'd0);
    send_item(FUNC_CLEAR, 4'd15, 6'd63);
    send_item(FUNC_ALLOC, 4'd0, 6'd0);

    // Values above the maxima saturate.
    wait_drain();
    write_reg(CFG_EPB, 7'd127);
    write_reg(CFG_NBLK, 7'd127);
    send_item(FUNC_ALLOC, 4'd0, 6'd0);
    send_item(FUNC_FREE, 4'd0, 6'd63);

    // Random phases under several settings; counts carry over between them.
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drain();
      case (p)
        0: begin
          write_reg(CFG_EPB, 7'd2);
          write_reg(CFG_NBLK, 7'd3);
        end
        1: begin
          write_reg(CFG_EPB, 7'd64);
          write_reg(CFG_NBLK, 7'd1);
        end
        2: begin
          write_reg(CFG_EPB, 7'd1);
          write_reg(CFG_NBLK, 7'd16);
        end
        3: begin
          write_reg(CFG_EPB, 7'd127);
          write_reg(CFG_NBLK, 7'd31);
        end
        4: begin
          write_reg(CFG_EPB, CFG_DATA_W'($urandom_range(0, 127)));
          write_reg(CFG_NBLK, CFG_DATA_W'($urandom_range(0, 127)));
        end
        default: begin
          write_reg(CFG_EPB, 7'd3);
          write_reg(CFG_NBLK, 7'd2);
        end
      endcase
      // Allocation-heavy first half, then a free-heavy second half.
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2) wait_drain();
        send_random_item(n < PHASE_ITEMS / 2 ? 65 : 35);
      end
    end

    wait_drain();
    repeat (8) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("tb_blocked_slot_pool_allocator_top: clean");
    end else begin
      $display("tb_blocked_slot_pool_allocator_top: errors");
    end
    $finish;
  end

endmodule
